### rtl/core/ptf_pkg.sv
// Package for the pressure trend forecaster: field widths, trend codes,
// and the Zambretti threshold, letter and picture tables.
// No dependencies.
`timescale 1ns / 1ps

package ptf_pkg;

    localparam int PRESS_W  = 14;
    localparam int MONTH_W  = 4;
    localparam int TREND_W  = 2;
    localparam int LETTER_W = 7;
    localparam int IMAGE_W  = 4;

    // Twice the Zambretti numerator, signed.
    localparam int NUM_W    = 18;
    // Number of thresholds compared per item (largest table plus one).
    localparam int THR_N    = 14;
    localparam int IDX_W    = 4;
    localparam int OFS_W    = 5;

    localparam logic [TREND_W-1:0] TREND_FALL   = 2'd0;
    localparam logic [TREND_W-1:0] TREND_STEADY = 2'd1;
    localparam logic [TREND_W-1:0] TREND_RISE   = 2'd2;

    localparam logic [LETTER_W-1:0] LETTER_A    = 7'd65;
    localparam logic [LETTER_W-1:0] LETTER_NONE = 7'd48;
    localparam logic [IMAGE_W-1:0]  IMAGE_NONE  = 4'd9;

    // A change of one whole hPa, in tenths.
    localparam int TREND_STEP = 10;

    localparam int FALL_COUNT   = 9;
    localparam int STEADY_COUNT = 10;
    localparam int RISE_COUNT   = 13;

    // Twice the numerator constant of each formula.
    localparam int FALL_BASE_WINTER = 2 * 81 * 131;
    localparam int FALL_BASE_SUMMER = 2 * 81 * 132;
    localparam int STEADY_BASE      = 2 * 147 * 376;
    localparam int RISE_BASE_WINTER = 2 * 129 * 178;
    localparam int RISE_BASE_SUMMER = 2 * 129 * 177;

    localparam logic signed [NUM_W-1:0] THR_NEVER = {1'b0, {(NUM_W-1){1'b1}}};

    // Z >= first + i exactly when twice the numerator reaches
    // den * (2 * (first + i) - 1). Thresholds past the table never match.
    function automatic logic signed [NUM_W-1:0] threshold(
        input logic [TREND_W-1:0] trend,
        input int                 i
    );
        logic signed [NUM_W-1:0] thr;
        thr = THR_NEVER;
        unique case (trend)
            TREND_FALL:
            begin
                if (i <= FALL_COUNT)
                    thr = NUM_W'(81 * (2 * (1 + i) - 1));
            end
            TREND_STEADY:
            begin
                if (i <= STEADY_COUNT)
                    thr = NUM_W'(376 * (2 * (10 + i) - 1));
            end
            TREND_RISE:
            begin
                if (i <= RISE_COUNT)
                    thr = NUM_W'(129 * (2 * (20 + i) - 1));
            end
            default:
            begin
                thr = THR_NEVER;
            end
        endcase
        return thr;
    endfunction

    function automatic int table_count(input logic [TREND_W-1:0] trend);
        int n;
        unique case (trend)
            TREND_FALL:   n = FALL_COUNT;
            TREND_STEADY: n = STEADY_COUNT;
            TREND_RISE:   n = RISE_COUNT;
            default:      n = 0;
        endcase
        return n;
    endfunction

    // Letter as an offset from 'A'.
    function automatic logic [OFS_W-1:0] letter_offset(
        input logic [TREND_W-1:0] trend,
        input logic [IDX_W-1:0]   idx
    );
        logic [OFS_W-1:0] ofs;
        ofs = '0;
        unique case (trend)
            TREND_FALL:
            begin
                unique case (idx)
                    4'd0:    ofs = 5'd0;   // A
                    4'd1:    ofs = 5'd1;   // B
                    4'd2:    ofs = 5'd3;   // D
                    4'd3:    ofs = 5'd7;   // H
                    4'd4:    ofs = 5'd14;  // O
                    4'd5:    ofs = 5'd17;  // R
                    4'd6:    ofs = 5'd20;  // U
                    4'd7:    ofs = 5'd21;  // V
                    4'd8:    ofs = 5'd23;  // X
                    default: ofs = 5'd0;
                endcase
            end
            TREND_STEADY:
            begin
                unique case (idx)
                    4'd0:    ofs = 5'd0;   // A
                    4'd1:    ofs = 5'd1;   // B
                    4'd2:    ofs = 5'd4;   // E
                    4'd3:    ofs = 5'd10;  // K
                    4'd4:    ofs = 5'd13;  // N
                    4'd5:    ofs = 5'd15;  // P
                    4'd6:    ofs = 5'd18;  // S
                    4'd7:    ofs = 5'd22;  // W
                    4'd8:    ofs = 5'd23;  // X
                    4'd9:    ofs = 5'd25;  // Z
                    default: ofs = 5'd0;
                endcase
            end
            TREND_RISE:
            begin
                unique case (idx)
                    4'd0:    ofs = 5'd0;   // A
                    4'd1:    ofs = 5'd1;   // B
                    4'd2:    ofs = 5'd2;   // C
                    4'd3:    ofs = 5'd5;   // F
                    4'd4:    ofs = 5'd6;   // G
                    4'd5:    ofs = 5'd8;   // I
                    4'd6:    ofs = 5'd9;   // J
                    4'd7:    ofs = 5'd11;  // L
                    4'd8:    ofs = 5'd12;  // M
                    4'd9:    ofs = 5'd16;  // Q
                    4'd10:   ofs = 5'd19;  // T
                    4'd11:   ofs = 5'd24;  // Y
                    4'd12:   ofs = 5'd25;  // Z
                    default: ofs = 5'd0;
                endcase
            end
            default:
            begin
                ofs = 5'd0;
            end
        endcase
        return ofs;
    endfunction

    function automatic logic [IMAGE_W-1:0] image_of(
        input logic [OFS_W-1:0] ofs,
        input logic             winter
    );
        logic [IMAGE_W-1:0] img;
        unique case (ofs)
            5'd0, 5'd1:
                img = 4'd1;
            5'd3, 5'd7, 5'd14, 5'd4, 5'd10, 5'd13, 5'd6, 5'd8:
                img = winter ? 4'd3 : 4'd2;
            5'd17, 5'd20, 5'd21, 5'd23, 5'd18, 5'd22:
                img = winter ? 4'd6 : 4'd5;
            5'd25, 5'd24:
                img = 4'd7;
            5'd15, 5'd9, 5'd11, 5'd12, 5'd19:
                img = 4'd8;
            5'd2, 5'd5, 5'd16:
                img = 4'd4;
            default:
                img = IMAGE_NONE;
        endcase
        return img;
    endfunction

endpackage

### rtl/core/ptf_if.sv
// Valid/ready channel interfaces for the pressure trend forecaster:
// one for measurement words in, one for forecast words out.
// Depends on ptf_pkg for the field widths.
`timescale 1ns / 1ps

interface ptf_meas_if;
    logic                         valid;
    logic                         ready;
    logic [ptf_pkg::PRESS_W-1:0]  pressure_now;
    logic [ptf_pkg::PRESS_W-1:0]  history_oldest;
    logic [ptf_pkg::PRESS_W-1:0]  history_newest;
    logic [ptf_pkg::MONTH_W-1:0]  month;

    modport source (output valid, pressure_now, history_oldest, history_newest, month,
                    input ready);
    modport sink   (input valid, pressure_now, history_oldest, history_newest, month,
                    output ready);
endinterface

interface ptf_fcst_if;
    logic                          valid;
    logic                          ready;
    logic [ptf_pkg::TREND_W-1:0]   trend_code;
    logic [ptf_pkg::LETTER_W-1:0]  forecast_letter;
    logic [ptf_pkg::IMAGE_W-1:0]   image_number;

    modport source (output valid, trend_code, forecast_letter, image_number,
                    input ready);
    modport sink   (input valid, trend_code, forecast_letter, image_number,
                    output ready);
endinterface

### rtl/core/pressure_trend_forecaster_top.sv
// Top level of the pressure trend forecaster: a three-stage pipeline.
// Depends on ptf_pkg and the channel interfaces in ptf_if.sv.
`timescale 1ns / 1ps

// Takes one measurement word per cycle while the output side does not stall, and
// returns one forecast word for each. The three register stages hold the trend
// and scaled Zambretti numerator, then a bank of parallel threshold compares
// that rounds the number into a table index, then the letter and picture
// lookups in the output register. A stalled stage holds its word while empty
// stages upstream of it keep filling.
module pressure_trend_forecaster_top (
    input  logic        clk,
    input  logic        rst_n,
    ptf_meas_if.sink    meas,
    ptf_fcst_if.source  fcst
);

    // Stage enables: a stage loads when it is empty or its word moves on.
    logic en1;
    logic en2;
    logic en3;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;

    // Stage 1 payload.
    logic [ptf_pkg::TREND_W-1:0]       s1_trend_reg;
    logic                              s1_winter_reg;
    logic                              s1_missing_reg;
    logic signed [ptf_pkg::NUM_W-1:0]  s1_num_reg;

    // Stage 2 payload.
    logic [ptf_pkg::TREND_W-1:0]       s2_trend_reg;
    logic                              s2_winter_reg;
    logic                              s2_missing_reg;
    logic                              s2_hit_reg;
    logic [ptf_pkg::IDX_W-1:0]         s2_idx_reg;

    // Stage 3 payload, which is the output.
    logic [ptf_pkg::TREND_W-1:0]       s3_trend_reg;
    logic [ptf_pkg::LETTER_W-1:0]      s3_letter_reg;
    logic [ptf_pkg::IMAGE_W-1:0]       s3_image_reg;

    // Stage 1 logic.
    logic signed [ptf_pkg::PRESS_W:0]  diff;
    logic                              winter;
    logic [ptf_pkg::TREND_W-1:0]       s1_trend_next;
    logic signed [ptf_pkg::NUM_W:0]    num_wide;
    logic signed [ptf_pkg::NUM_W:0]    press_ext;

    // Stage 2 logic.
    logic [ptf_pkg::THR_N-1:0]         ge;
    logic [ptf_pkg::IDX_W-1:0]         ones;
    logic [ptf_pkg::IDX_W-1:0]         count;
    logic                              s2_hit_next;

    // Stage 3 logic.
    logic [ptf_pkg::OFS_W-1:0]         ofs;

    assign en3 = !s3_valid_reg || fcst.ready;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign meas.ready = en1;

    // Trend, season and twice the Zambretti numerator.
    always_comb
    begin
        diff = $signed({1'b0, meas.history_newest}) - $signed({1'b0, meas.history_oldest});
        winter = (meas.month < ptf_pkg::MONTH_W'(4)) || (meas.month > ptf_pkg::MONTH_W'(9));
        press_ext = $signed({{(ptf_pkg::NUM_W + 1 - ptf_pkg::PRESS_W){1'b0}},
                             meas.pressure_now});
        if (diff >= (ptf_pkg::PRESS_W + 1)'(ptf_pkg::TREND_STEP))
            s1_trend_next = ptf_pkg::TREND_RISE;
        else if (diff <= -(ptf_pkg::PRESS_W + 1)'(ptf_pkg::TREND_STEP))
            s1_trend_next = ptf_pkg::TREND_FALL;
        else
            s1_trend_next = ptf_pkg::TREND_STEADY;

        unique case (s1_trend_next)
            ptf_pkg::TREND_FALL:
            begin
                num_wide = (winter ? (ptf_pkg::NUM_W + 1)'(ptf_pkg::FALL_BASE_WINTER)
                                   : (ptf_pkg::NUM_W + 1)'(ptf_pkg::FALL_BASE_SUMMER))
                           - (press_ext <<< 1);
            end
            ptf_pkg::TREND_RISE:
            begin
                num_wide = (winter ? (ptf_pkg::NUM_W + 1)'(ptf_pkg::RISE_BASE_WINTER)
                                   : (ptf_pkg::NUM_W + 1)'(ptf_pkg::RISE_BASE_SUMMER))
                           - (press_ext <<< 2);
            end
            default:
            begin
                num_wide = (ptf_pkg::NUM_W + 1)'(ptf_pkg::STEADY_BASE)
                           - (press_ext <<< 3) - (press_ext <<< 1);
            end
        endcase
    end

    // Rounding half away from zero: Z reaches first + i exactly when the
    // doubled numerator reaches den * (2 * (first + i) - 1). The hits form
    // a thermometer code whose population is the rounded number minus first, plus one.
    always_comb
    begin
        for (int i = 0; i < ptf_pkg::THR_N; i++)
        begin
            ge[i] = s1_num_reg >= ptf_pkg::threshold(s1_trend_reg, i);
        end
        ones = ptf_pkg::IDX_W'($countones(ge));
        count = ptf_pkg::IDX_W'(ptf_pkg::table_count(s1_trend_reg));
        s2_hit_next = (ones != '0) && (ones <= count);
    end

    assign ofs = ptf_pkg::letter_offset(s2_trend_reg, s2_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= meas.valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_trend_reg   <= s1_trend_next;
            s1_winter_reg  <= winter;
            s1_missing_reg <= (meas.history_oldest == '0);
            s1_num_reg     <= ptf_pkg::NUM_W'(num_wide);
        end
        if (en2)
        begin
            s2_trend_reg   <= s1_trend_reg;
            s2_winter_reg  <= s1_winter_reg;
            s2_missing_reg <= s1_missing_reg;
            s2_hit_reg     <= s2_hit_next;
            s2_idx_reg     <= ones - ptf_pkg::IDX_W'(1);
        end
        if (en3)
        begin
            s3_trend_reg <= s2_trend_reg;
            if (s2_hit_reg)
                s3_letter_reg <= ptf_pkg::LETTER_A + ptf_pkg::LETTER_W'(ofs);
            else
                s3_letter_reg <= ptf_pkg::LETTER_NONE;
            if (s2_missing_reg || !s2_hit_reg)
                s3_image_reg <= ptf_pkg::IMAGE_NONE;
            else
                s3_image_reg <= ptf_pkg::image_of(ofs, s2_winter_reg);
        end
    end

    assign fcst.valid           = s3_valid_reg;
    assign fcst.trend_code      = s3_trend_reg;
    assign fcst.forecast_letter = s3_letter_reg;
    assign fcst.image_number    = s3_image_reg;

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        meas.valid && meas.ready |=> s1_valid_reg)
        else $error("accepted word did not enter the first stage");

    a_no_letter_no_image: assert property (@(posedge clk) disable iff (!rst_n)
        fcst.valid && fcst.forecast_letter == ptf_pkg::LETTER_NONE
        |-> fcst.image_number == ptf_pkg::IMAGE_NONE)
        else $error("out-of-table forecast carries a picture");

    a_image_range: assert property (@(posedge clk) disable iff (!rst_n)
        fcst.valid |-> fcst.image_number >= 4'd1 && fcst.image_number <= ptf_pkg::IMAGE_NONE)
        else $error("picture index out of range");

    a_trend_code: assert property (@(posedge clk) disable iff (!rst_n)
        fcst.valid |-> fcst.trend_code == ptf_pkg::TREND_FALL
                    || fcst.trend_code == ptf_pkg::TREND_STEADY
                    || fcst.trend_code == ptf_pkg::TREND_RISE)
        else $error("invalid trend code");

    a_s2_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !en2 |=> s2_valid_reg && $stable(s2_idx_reg) && $stable(s2_hit_reg))
        else $error("middle stage lost its word during a stall");

endmodule

### tb/testbench.sv
// Self-checking testbench for pressure_trend_forecaster_top: random bursts of
// measurement words against an in-bench forecast predictor.
// Depends on ptf_pkg, ptf_if.sv and the forecaster RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 12;
    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_CYCLES  = 80;

    typedef struct packed {
        logic [ptf_pkg::PRESS_W-1:0] pressure;
        logic [ptf_pkg::PRESS_W-1:0] oldest;
        logic [ptf_pkg::PRESS_W-1:0] newest;
        logic [ptf_pkg::MONTH_W-1:0] month;
    } meas_t;

    typedef struct packed {
        logic [ptf_pkg::TREND_W-1:0]  trend;
        logic [ptf_pkg::LETTER_W-1:0] letter;
        logic [ptf_pkg::IMAGE_W-1:0]  image;
    } fcst_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        drv_valid = 1'b0;
    logic [ptf_pkg::PRESS_W-1:0] drv_pressure = '0;
    logic [ptf_pkg::PRESS_W-1:0] drv_oldest = '0;
    logic [ptf_pkg::PRESS_W-1:0] drv_newest = '0;
    logic [ptf_pkg::MONTH_W-1:0] drv_month = '0;
    logic                        drv_ready = 1'b0;

    ptf_meas_if meas_ch ();
    ptf_fcst_if fcst_ch ();

    assign meas_ch.valid          = drv_valid;
    assign meas_ch.pressure_now   = drv_pressure;
    assign meas_ch.history_oldest = drv_oldest;
    assign meas_ch.history_newest = drv_newest;
    assign meas_ch.month          = drv_month;
    assign fcst_ch.ready          = drv_ready;

    pressure_trend_forecaster_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .meas  (meas_ch),
        .fcst  (fcst_ch)
    );

    meas_t meas_backlog[$];
    fcst_t forecasts_due[$];

    logic in_fire = 1'b0;
    int   errors = 0;
    int   cycles = 0;
    int   meas_count = 0;
    int   fcst_count = 0;
    int   falling_seen = 0;
    int   steady_seen = 0;
    int   rising_seen = 0;
    int   missing_seen = 0;
    int   off_table_seen = 0;
    int   holds_done = 0;

    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int hold_at = 250;
    int stall_mode = 0;
    int mode_left = 0;
    int rcv_phase = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Expected forecast for one measurement word, with exact rounding of
    // the Zambretti number half away from zero.
    function automatic fcst_t forecast_of(meas_t m);
        int    p;
        int    old_p;
        int    new_p;
        int    d;
        int    num;
        int    den;
        int    mag;
        int    z;
        int    first;
        bit    winter;
        string tab;
        byte   ch;
        fcst_t r;
        p      = m.pressure;
        old_p  = m.oldest;
        new_p  = m.newest;
        d      = new_p - old_p;
        winter = (m.month < 4) || (m.month > 9);
        if (d >= ptf_pkg::TREND_STEP)
            r.trend = ptf_pkg::TREND_RISE;
        else if (d <= -ptf_pkg::TREND_STEP)
            r.trend = ptf_pkg::TREND_FALL;
        else
            r.trend = ptf_pkg::TREND_STEADY;
        if (r.trend == ptf_pkg::TREND_FALL)
        begin
            num   = 81 * (winter ? 131 : 132) - p;
            den   = 81;
            first = 1;
            tab   = "ABDHORUVX";
        end
        else if (r.trend == ptf_pkg::TREND_STEADY)
        begin
            num   = 147 * 376 - 5 * p;
            den   = 376;
            first = 10;
            tab   = "ABEKNPSWXZ";
        end
        else
        begin
            num   = 129 * (winter ? 178 : 177) - 2 * p;
            den   = 129;
            first = 20;
            tab   = "ABCFGIJLMQTYZ";
        end
        mag = (num < 0) ? -num : num;
        z   = (2 * mag + den) / (2 * den);
        if (num < 0)
            z = -z;
        if (z >= first && z < first + tab.len())
            ch = tab[z - first];
        else
            ch = byte'(ptf_pkg::LETTER_NONE);
        r.letter = ch[ptf_pkg::LETTER_W-1:0];
        if (old_p == 0)
            r.image = ptf_pkg::IMAGE_NONE;
        else
        begin
            case (ch)
                "A", "B":                               r.image = 4'd1;
                "D", "H", "O", "E", "K", "N", "G", "I": r.image = winter ? 4'd3 : 4'd2;
                "R", "U", "V", "X", "S", "W":           r.image = winter ? 4'd6 : 4'd5;
                "Z", "Y":                               r.image = 4'd7;
                "P", "J", "L", "M", "T":                r.image = 4'd8;
                "C", "F", "Q":                          r.image = 4'd4;
                default:                                r.image = ptf_pkg::IMAGE_NONE;
            endcase
        end
        return r;
    endfunction

    task automatic add_meas(int p, int o, int n, int mo);
        meas_t m;
        if (n < 0)
            n = 0;
        if (n > 16383)
            n = 16383;
        m.pressure = p[ptf_pkg::PRESS_W-1:0];
        m.oldest   = o[ptf_pkg::PRESS_W-1:0];
        m.newest   = n[ptf_pkg::PRESS_W-1:0];
        m.month    = mo[ptf_pkg::MONTH_W-1:0];
        meas_backlog.push_back(m);
    endtask

    // Sender: bursts of words with random gaps; a word stays up until taken.
    always @(negedge clk)
    begin
        meas_t nxt;
        logic  vld;
        int    pick;
        if (rst_n)
        begin
            vld = drv_valid;
            if (in_fire)
                vld = 1'b0;
            if (!vld)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (meas_backlog.size() > 0)
                begin
                    nxt          = meas_backlog.pop_front();
                    drv_pressure <= nxt.pressure;
                    drv_oldest   <= nxt.oldest;
                    drv_newest   <= nxt.newest;
                    drv_month    <= nxt.month;
                    vld          = 1'b1;
                    if (burst_left <= 1)
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick < 2)
                        begin
                            burst_left <= $urandom_range(40, 100);
                            gap_left   <= 0;
                        end
                        else
                        begin
                            burst_left <= $urandom_range(1, 16);
                            gap_left   <= $urandom_range(0, 6);
                        end
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
            drv_valid <= vld;
        end
    end

    // Receiver: changing stall patterns, plus long hold-offs that back the
    // pipeline up into its input.
    always @(negedge clk)
    begin
        logic rdy;
        if (rst_n)
        begin
            rdy = 1'b1;
            rcv_phase <= rcv_phase + 1;
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rdy = 1'b0;
            end
            else if (fcst_count >= hold_at)
            begin
                hold_left  <= HOLD_CYCLES - 1;
                hold_at    <= hold_at + 350;
                holds_done <= holds_done + 1;
                rdy = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode <= $urandom_range(0, 3);
                    mode_left  <= $urandom_range(8, 64);
                end
                else
                    mode_left <= mode_left - 1;
                case (stall_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 1) == 1);
                    2:       rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = (rcv_phase % 3 != 2);
                endcase
            end
            drv_ready <= rdy;
        end
    end

    // Monitor: compare each forecast word with the oldest one due, then
    // record the prediction for any measurement word taken at this edge.
    always @(posedge clk)
    begin
        meas_t m;
        fcst_t got;
        fcst_t want;
        if (rst_n)
        begin
            in_fire <= meas_ch.valid && meas_ch.ready;
            if (fcst_ch.valid && fcst_ch.ready)
            begin
                got.trend  = fcst_ch.trend_code;
                got.letter = fcst_ch.forecast_letter;
                got.image  = fcst_ch.image_number;
                fcst_count <= fcst_count + 1;
                if (forecasts_due.size() == 0)
                begin
                    $error("forecast word with none due: trend %0d letter %0d image %0d",
                           got.trend, got.letter, got.image);
                    errors = errors + 1;
                end
                else
                begin
                    want = forecasts_due.pop_front();
                    if (got.trend !== want.trend)
                    begin
                        $error("trend_code: expected %0d, actual %0d", want.trend, got.trend);
                        errors = errors + 1;
                    end
                    if (got.letter !== want.letter)
                    begin
                        $error("forecast_letter: expected %0d, actual %0d",
                               want.letter, got.letter);
                        errors = errors + 1;
                    end
                    if (got.image !== want.image)
                    begin
                        $error("image_number: expected %0d, actual %0d", want.image, got.image);
                        errors = errors + 1;
                    end
                end
            end
            if (meas_ch.valid && meas_ch.ready)
            begin
                m.pressure = meas_ch.pressure_now;
                m.oldest   = meas_ch.history_oldest;
                m.newest   = meas_ch.history_newest;
                m.month    = meas_ch.month;
                want = forecast_of(m);
                forecasts_due.push_back(want);
                meas_count <= meas_count + 1;
                if (want.trend == ptf_pkg::TREND_FALL)
                    falling_seen <= falling_seen + 1;
                else if (want.trend == ptf_pkg::TREND_STEADY)
                    steady_seen <= steady_seen + 1;
                else
                    rising_seen <= rising_seen + 1;
                if (m.oldest == '0)
                    missing_seen <= missing_seen + 1;
                if (want.letter == ptf_pkg::LETTER_NONE)
                    off_table_seen <= off_table_seen + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d forecast words still due",
                     cycles, forecasts_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int o;
        int sel;
        int p;
        int delta;
        int mo;

        // Field extremes, missing history and an empty history.
        add_meas(0, 0, 0, 0);
        add_meas(16383, 16383, 16383, 15);
        add_meas(8000, 0, 16383, 6);
        add_meas(10000, 16383, 0, 7);
        // Trend thresholds on either side of one whole hPa.
        add_meas(10000, 10000, 10010, 5);
        add_meas(10000, 10000, 10009, 5);
        add_meas(10000, 10000, 9991, 11);
        add_meas(10000, 10000, 9990, 11);
        // Steady value exactly halfway between two Zambretti numbers.
        add_meas(9964, 10000, 10000, 8);
        // Every month code, in range or not, across all three trends.
        for (int k = 0; k < 16; k++)
            add_meas(9800 + 50 * k, 10000, 10000 + ((k % 3) - 1) * 30, k);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 15)
                add_meas($urandom_range(0, 16383), $urandom_range(0, 16383),
                         $urandom_range(0, 16383), $urandom_range(0, 15));
            else
            begin
                p = $urandom_range(9300, 10700);
                o = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(9300, 10700);
                if ($urandom_range(0, 2) == 0)
                    delta = $urandom_range(0, 24) - 12;
                else
                    delta = $urandom_range(0, 160) - 80;
                if ($urandom_range(0, 9) == 0)
                    mo = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15);
                else
                    mo = $urandom_range(1, 12);
                add_meas(p, o, o + delta, mo);
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (meas_backlog.size() != 0 || drv_valid)
            @(posedge clk);
        while (forecasts_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d measurement words in, %0d forecasts out, %0d long output hold-offs",
                 meas_count, fcst_count, holds_done);
        $display("Trends falling/steady/rising %0d/%0d/%0d; missing history %0d, off table %0d",
                 falling_seen, steady_seen, rising_seen, missing_seen, off_table_seen);
        if (errors == 0 && forecasts_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
